@@ rtl/ttfc_pkg.sv @@
// ttfc_pkg: shared constants, request codes and the result layout of the
// touch tap/flick classifier. No dependencies.
`default_nettype none

package ttfc_pkg;

    // geometry and history
    localparam int COORD_BITS         = 12;
    localparam int MOVE_HISTORY_DEPTH = 4;
    localparam int MOVE_W             = COORD_BITS + 1;
    localparam int SUM_W              = MOVE_W + $clog2(MOVE_HISTORY_DEPTH);
    localparam int HOLD_W             = 16;

    // configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] STABLE_DIST_RST = 8'd4;
    localparam logic [CFG_W-1:0] FLICK_DIST_RST  = 8'd20;
    localparam logic [CFG_W-1:0] TAP_WIN_RST     = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STABLE_DIST = 2'd0,
        CFG_FLICK_DIST  = 2'd1,
        CFG_TAP_WINDOW  = 2'd2
    } cfg_idx_t;

    // request kinds carried on s_tuser
    localparam int REQ_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_DOWN = 2'd0,
        REQ_UP   = 2'd1,
        REQ_MOVE = 2'd2,
        REQ_TICK = 2'd3
    } req_t;

    // result item, touched_down in bit 0
    typedef struct packed {
        logic        [HOLD_W-1:0] press_frames;
        logic signed [SUM_W-1:0]  flick_y;
        logic signed [SUM_W-1:0]  flick_x;
        logic signed [MOVE_W-1:0] move_y;
        logic signed [MOVE_W-1:0] move_x;
        logic                     active;
        logic                     pressed;
        logic                     flicked;
        logic                     tapped;
        logic                     moved;
        logic                     touched_up;
        logic                     touched_down;
    } res_t;

    localparam int RES_W     = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = REQ_W;

endpackage

`default_nettype wire

@@ rtl/touch_tap_flick_classifier.sv @@
// touch_tap_flick_classifier: one-finger tap/flick gesture classifier.
// A frame tick is taken into the input register and then into the result register,
// which raises m_tvalid; down/up/move items give no result.
// Throughput: one item per cycle; the only stall is a full result register
// that the sink does not take while a frame tick waits in the input register.
// Reset (aresetn low, synchronous): all state, pending flags and histories
// clear; thresholds return to 4, 20 and 10. Depends on ttfc_pkg.
`default_nettype none

module touch_tap_flick_classifier (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [11:0] x_pos, [23:12] y_pos
    input  wire logic [ttfc_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  wire logic [ttfc_pkg::S_TUSER_W-1:0] s_tuser,
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] touched_down, [1] touched_up, [2] moved, [3] tapped, [4] flicked,
    // [5] pressed, [6] active, [19:7] move_x, [32:20] move_y,
    // [47:33] flick_x, [62:48] flick_y, [78:63] press_frames, [79] zero
    output logic [ttfc_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttfc_pkg::CFG_W-1:0]     cfg_data
);
    import ttfc_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] stable_dist_reg, flick_dist_reg, tap_win_reg;

    // input register
    logic                  in_vld_reg;
    req_t                  in_req_reg;
    logic [COORD_BITS-1:0] in_x_reg, in_y_reg;

    // result register
    logic out_vld_reg;
    res_t res_reg, res_next;

    // gesture state
    logic                  pend_down_reg, pend_up_reg, pend_moved_reg, pend_down_up_reg;
    logic [COORD_BITS-1:0] pend_x_reg, pend_y_reg;
    logic                  held_reg, stable_reg;
    logic [CFG_W-1:0]      tap_timer_reg;
    logic [HOLD_W-1:0]     hold_count_reg;
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg, start_x_reg, start_y_reg;
    logic signed [MOVE_W-1:0] hist_x_reg [MOVE_HISTORY_DEPTH];
    logic signed [MOVE_W-1:0] hist_y_reg [MOVE_HISTORY_DEPTH];
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg;

    // frame tick next values
    logic                  held_next, stable_next;
    logic [CFG_W-1:0]      tap_timer_next;
    logic [HOLD_W-1:0]     hold_count_next;
    logic [COORD_BITS-1:0] prev_x_next, prev_y_next, start_x_next, start_y_next;
    logic signed [MOVE_W-1:0] hist_x_next [MOVE_HISTORY_DEPTH];
    logic signed [MOVE_W-1:0] hist_y_next [MOVE_HISTORY_DEPTH];
    logic signed [SUM_W-1:0]  sum_x_next, sum_y_next;

    logic advance, in_is_tick;

    // handshakes
    assign in_is_tick = (in_req_reg == REQ_TICK);
    assign advance    = in_vld_reg && (!in_is_tick || !out_vld_reg || m_tready);
    assign s_tready   = !in_vld_reg || advance;
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = M_TDATA_W'(res_reg);
    assign cfg_ready  = 1'b1;

    // frame tick evaluation
    always_comb begin
        logic                     down_eff, mv, tap, flk, fl_hit;
        logic                     held_a, stable_a;
        logic [CFG_W-1:0]         timer_a;
        logic [COORD_BITS-1:0]    prev_ax, prev_ay, start_ax, start_ay;
        logic signed [MOVE_W-1:0] mx, my, dx, dy;
        logic signed [2*MOVE_W-1:0] dx_sq, dy_sq;
        logic [2*MOVE_W:0]        dist_sq;
        logic signed [SUM_W-1:0]  sx, sy;
        logic signed [2*SUM_W-1:0] sx_sq, sy_sq;
        logic [2*SUM_W:0]         flick_sq;
        logic [2*CFG_W-1:0]       stable_lim_sq, flick_lim_sq;

        // apply a pending touch down
        down_eff = pend_down_reg || pend_down_up_reg;
        held_a   = down_eff ? 1'b1 : held_reg;
        stable_a = down_eff ? 1'b1 : stable_reg;
        timer_a  = down_eff ? tap_win_reg : tap_timer_reg;
        hold_count_next = down_eff ? '0 : hold_count_reg;
        start_ax = down_eff ? pend_x_reg : start_x_reg;
        start_ay = down_eff ? pend_y_reg : start_y_reg;
        prev_ax  = down_eff ? pend_x_reg : prev_x_reg;
        prev_ay  = down_eff ? pend_y_reg : prev_y_reg;

        // move delta and distance from start
        mv = pend_moved_reg && ((pend_x_reg != prev_ax) || (pend_y_reg != prev_ay));
        mx = mv ? (signed'({1'b0, pend_x_reg}) - signed'({1'b0, prev_ax})) : '0;
        my = mv ? (signed'({1'b0, pend_y_reg}) - signed'({1'b0, prev_ay})) : '0;
        dx = signed'({1'b0, pend_x_reg}) - signed'({1'b0, start_ax});
        dy = signed'({1'b0, pend_y_reg}) - signed'({1'b0, start_ay});
        dx_sq = (2*MOVE_W)'(dx) * (2*MOVE_W)'(dx);
        dy_sq = (2*MOVE_W)'(dy) * (2*MOVE_W)'(dy);
        dist_sq = {1'b0, unsigned'(dx_sq)} + {1'b0, unsigned'(dy_sq)};
        stable_lim_sq = (2*CFG_W)'(stable_dist_reg) * (2*CFG_W)'(stable_dist_reg);
        stable_next = stable_a;
        if (mv && (dist_sq >= (2*MOVE_W+1)'(stable_lim_sq))) begin
            stable_next = 1'b0;
        end
        prev_x_next  = mv ? pend_x_reg : prev_ax;
        prev_y_next  = mv ? pend_y_reg : prev_ay;
        start_x_next = start_ax;
        start_y_next = start_ay;

        // history shift with running sums
        sx = sum_x_reg - SUM_W'(hist_x_reg[MOVE_HISTORY_DEPTH-1]) + SUM_W'(mx);
        sy = sum_y_reg - SUM_W'(hist_y_reg[MOVE_HISTORY_DEPTH-1]) + SUM_W'(my);
        for (int i = MOVE_HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_x_next[i] = hist_x_reg[i-1];
            hist_y_next[i] = hist_y_reg[i-1];
        end
        hist_x_next[0] = mx;
        hist_y_next[0] = my;
        sum_x_next = sx;
        sum_y_next = sy;

        // flick length check on the summed history
        sx_sq = (2*SUM_W)'(sx) * (2*SUM_W)'(sx);
        sy_sq = (2*SUM_W)'(sy) * (2*SUM_W)'(sy);
        flick_sq = {1'b0, unsigned'(sx_sq)} + {1'b0, unsigned'(sy_sq)};
        flick_lim_sq = (2*CFG_W)'(flick_dist_reg) * (2*CFG_W)'(flick_dist_reg);
        fl_hit = flick_sq > (2*SUM_W+1)'(flick_lim_sq);

        // release classification
        tap = 1'b0;
        flk = 1'b0;
        held_next = held_a;
        tap_timer_next = timer_a;
        if (pend_up_reg) begin
            held_next = 1'b0;
            tap = (timer_a != '0) && stable_next;
            flk = !tap && fl_hit;
            tap_timer_next = '0;
            hold_count_next = '0;
            for (int i = 0; i < MOVE_HISTORY_DEPTH; i++) begin
                hist_x_next[i] = '0;
                hist_y_next[i] = '0;
            end
            sum_x_next = '0;
            sum_y_next = '0;
        end

        // held frame counting
        if (held_next) begin
            if (tap_timer_next != '0) begin
                tap_timer_next = tap_timer_next - 1'b1;
            end
            if (hold_count_next != '1) begin
                hold_count_next = hold_count_next + 1'b1;
            end
        end

        // result item
        res_next.touched_down = down_eff;
        res_next.touched_up   = pend_up_reg;
        res_next.moved        = mv;
        res_next.tapped       = tap;
        res_next.flicked      = flk;
        res_next.pressed      = held_next;
        res_next.active       = held_reg || pend_down_up_reg || held_next;
        res_next.move_x       = mx;
        res_next.move_y       = my;
        res_next.flick_x      = flk ? sx : '0;
        res_next.flick_y      = flk ? sy : '0;
        res_next.press_frames = hold_count_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_dist_reg <= STABLE_DIST_RST;
            flick_dist_reg  <= FLICK_DIST_RST;
            tap_win_reg     <= TAP_WIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_STABLE_DIST: stable_dist_reg <= cfg_data;
                CFG_FLICK_DIST:  flick_dist_reg  <= cfg_data;
                CFG_TAP_WINDOW:  tap_win_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_req_reg <= req_t'(s_tuser[REQ_W-1:0]);
            in_x_reg   <= s_tdata[COORD_BITS-1:0];
            in_y_reg   <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_is_tick) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance && in_is_tick) begin
            res_reg <= res_next;
        end
    end

    // pending events and gesture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_down_reg    <= 1'b0;
            pend_up_reg      <= 1'b0;
            pend_moved_reg   <= 1'b0;
            pend_down_up_reg <= 1'b0;
            pend_x_reg       <= '0;
            pend_y_reg       <= '0;
            held_reg         <= 1'b0;
            stable_reg       <= 1'b0;
            tap_timer_reg    <= '0;
            hold_count_reg   <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            for (int i = 0; i < MOVE_HISTORY_DEPTH; i++) begin
                hist_x_reg[i] <= '0;
                hist_y_reg[i] <= '0;
            end
        end else if (advance) begin
            unique case (in_req_reg)
                REQ_DOWN: begin
                    pend_down_reg <= 1'b1;
                    pend_up_reg   <= 1'b0;
                    pend_x_reg    <= in_x_reg;
                    pend_y_reg    <= in_y_reg;
                end
                REQ_UP: begin
                    pend_up_reg    <= 1'b1;
                    pend_moved_reg <= 1'b1;
                    pend_x_reg     <= in_x_reg;
                    pend_y_reg     <= in_y_reg;
                    if (pend_down_reg) begin
                        pend_down_reg    <= 1'b0;
                        pend_down_up_reg <= 1'b1;
                    end
                end
                REQ_MOVE: begin
                    pend_moved_reg <= 1'b1;
                    pend_x_reg     <= in_x_reg;
                    pend_y_reg     <= in_y_reg;
                end
                REQ_TICK: begin
                    pend_down_reg    <= 1'b0;
                    pend_up_reg      <= 1'b0;
                    pend_moved_reg   <= 1'b0;
                    pend_down_up_reg <= 1'b0;
                    pend_x_reg       <= '0;
                    pend_y_reg       <= '0;
                    held_reg         <= held_next;
                    stable_reg       <= stable_next;
                    tap_timer_reg    <= tap_timer_next;
                    hold_count_reg   <= hold_count_next;
                    prev_x_reg       <= prev_x_next;
                    prev_y_reg       <= prev_y_next;
                    start_x_reg      <= start_x_next;
                    start_y_reg      <= start_y_next;
                    sum_x_reg        <= sum_x_next;
                    sum_y_reg        <= sum_y_next;
                    for (int i = 0; i < MOVE_HISTORY_DEPTH; i++) begin
                        hist_x_reg[i] <= hist_x_next[i];
                        hist_y_reg[i] <= hist_y_next[i];
                    end
                end
                default: ;
            endcase
        end
    end

    // a release is either a tap or a flick, never both
    a_tap_flick_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_reg.tapped && res_reg.flicked))
        else $error("tap and flick reported together");

    // tap or flick only on a release, and a release leaves the finger up
    a_release_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res_reg.tapped || res_reg.flicked || res_reg.touched_up))
        |-> (res_reg.touched_up && !res_reg.pressed))
        else $error("classification without release");

    // with no finger held the counters stay cleared
    a_idle_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_reg |-> (hold_count_reg == '0 && tap_timer_reg == '0))
        else $error("counters running while not held");

    // a result waiting for the sink holds still
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
